FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the list store datapath.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant checked at every clock edge outside reset.
`define ILS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define ILS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/ils_pkg.sv
// ---------------------------------------------------------------------------
// ils_pkg
// Sizes, request and status codes, and the command and status types that
// join the list store controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 9;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_OVERWRITE = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_VAL_RD,
    S_VAL_WR,
    S_INS_HEAD,
    S_INS_TAIL,
    S_INS_RD,
    S_INS_LINK,
    S_INS_FIX,
    S_RM_HEAD_RD,
    S_RM_HEAD_UPD,
    S_RM_RD1,
    S_RM_RD2,
    S_RM_UPD,
    S_FINISH
  } ctrl_state_t;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CHECK,
    DP_WALK,
    DP_VAL_RD,
    DP_VAL_WR,
    DP_INS_HEAD,
    DP_INS_TAIL,
    DP_LINK_RD_TGT,
    DP_INS_LINK,
    DP_INS_FIX,
    DP_RM_HEAD_RD,
    DP_RM_HEAD_UPD,
    DP_RM_RD2,
    DP_RM_UPD,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] err;
    logic                is_ins;
    logic                is_rm;
    logic                is_rd;
    logic                is_ovw;
    logic                at_head;
    logic                at_tail;
    logic                walk_done;
    logic                out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/indexed_list_store.sv
// A rejected request goes from the check straight to the result; append or
// insert at either end and a head remove skip the chain walk, while read,
// overwrite, a middle insert and any other remove first walk the chain to the
// position. Results wait in an output register.
// Requests are handled one at a time; in_ready is high only while idle.
// Reset empties the list at once with no clearing pass.
// ---------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed values kept as a linked chain of slots,
// with append, positional insert, remove, read and overwrite requests.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ils_pkg::REQ_W-1:0]             in_req_type,
  input  logic [ils_pkg::POS_W-1:0]             in_position,
  input  logic signed [ils_pkg::VALUE_BITS-1:0] in_write_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ils_pkg::STATUS_W-1:0]          out_status,
  output logic signed [ils_pkg::VALUE_BITS-1:0] out_read_value,
  output logic [ils_pkg::LEN_W-1:0]             out_entry_count
);
  import ils_pkg::*;

  dp_op_t     cmd_op;
  dp_status_t sts;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd_op   (cmd_op)
  );

  ils_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_op          (cmd_op),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

FILE: hdl/ils_ctrl.sv
// ---------------------------------------------------------------------------
// ils_ctrl
// Sequencer of the list store: steps each request through check, chain walk,
// link and value updates, one micro-op a cycle; finish waits on busy output.
// ---------------------------------------------------------------------------
`default_nettype none

module ils_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ils_pkg::dp_status_t sts,
  output ils_pkg::dp_op_t     cmd_op
);
  import ils_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.err != ST_DONE) state_nxt = S_FINISH;
        else if (sts.is_rd || sts.is_ovw) state_nxt = S_WALK;
        else if (sts.is_ins) begin
          priority if (sts.at_head) state_nxt = S_INS_HEAD;
          else if (sts.at_tail) state_nxt = S_INS_TAIL;
          else state_nxt = S_WALK;
        end else if (sts.is_rm) begin
          state_nxt = sts.at_head ? S_RM_HEAD_RD : S_WALK;
        end else state_nxt = S_FINISH;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          priority if (sts.is_rd) state_nxt = S_VAL_RD;
          else if (sts.is_ovw) state_nxt = S_VAL_WR;
          else if (sts.is_ins) state_nxt = S_INS_RD;
          else state_nxt = S_RM_RD1;
        end
      end
      S_VAL_RD:      state_nxt = S_FINISH;
      S_VAL_WR:      state_nxt = S_FINISH;
      S_INS_HEAD:    state_nxt = S_FINISH;
      S_INS_TAIL:    state_nxt = S_FINISH;
      S_INS_RD:      state_nxt = S_INS_LINK;
      S_INS_LINK:    state_nxt = S_INS_FIX;
      S_INS_FIX:     state_nxt = S_FINISH;
      S_RM_HEAD_RD:  state_nxt = S_RM_HEAD_UPD;
      S_RM_HEAD_UPD: state_nxt = S_FINISH;
      S_RM_RD1:      state_nxt = S_RM_RD2;
      S_RM_RD2:      state_nxt = S_RM_UPD;
      S_RM_UPD:      state_nxt = S_FINISH;
      S_FINISH: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default:       state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd_op   = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd_op = DP_LOAD;
      end
      S_CHECK:       cmd_op = DP_CHECK;
      S_WALK:        cmd_op = DP_WALK;
      S_VAL_RD:      cmd_op = DP_VAL_RD;
      S_VAL_WR:      cmd_op = DP_VAL_WR;
      S_INS_HEAD:    cmd_op = DP_INS_HEAD;
      S_INS_TAIL:    cmd_op = DP_INS_TAIL;
      S_INS_RD:      cmd_op = DP_LINK_RD_TGT;
      S_INS_LINK:    cmd_op = DP_INS_LINK;
      S_INS_FIX:     cmd_op = DP_INS_FIX;
      S_RM_HEAD_RD:  cmd_op = DP_RM_HEAD_RD;
      S_RM_HEAD_UPD: cmd_op = DP_RM_HEAD_UPD;
      S_RM_RD1:      cmd_op = DP_LINK_RD_TGT;
      S_RM_RD2:      cmd_op = DP_RM_RD2;
      S_RM_UPD:      cmd_op = DP_RM_UPD;
      S_FINISH: begin
        if (!sts.out_busy) cmd_op = DP_FINISH;
      end
      default:       cmd_op = DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/ils_dpath.sv
// ---------------------------------------------------------------------------
// ils_dpath
// Datapath of the list store: value, link and free-slot memories, chain
// ends, entry count, walk cursor and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ils_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ils_pkg::dp_op_t                       cmd_op,
  output ils_pkg::dp_status_t                   sts,
  input  logic [ils_pkg::REQ_W-1:0]             in_req_type,
  input  logic [ils_pkg::POS_W-1:0]             in_position,
  input  logic signed [ils_pkg::VALUE_BITS-1:0] in_write_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ils_pkg::STATUS_W-1:0]          out_status,
  output logic signed [ils_pkg::VALUE_BITS-1:0] out_read_value,
  output logic [ils_pkg::LEN_W-1:0]             out_entry_count
);
  import ils_pkg::*;

  // Storage. The free-slot stack reads as its reset content (slot i at
  // place i) until a place has been written.
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0]     link_mem [CAPACITY];
  logic [SLOT_W-1:0]     free_mem [CAPACITY];
  logic [CAPACITY-1:0]   free_vld_r;

  // Request registers.
  logic [REQ_W-1:0]      req_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] wv_r;
  logic [STATUS_W-1:0]   status_r;

  // List state.
  logic [LEN_W-1:0]  len_r;
  logic [SLOT_W-1:0] first_r;
  logic [SLOT_W-1:0] last_r;

  // Walk and read-back registers.
  logic [SLOT_W-1:0]     rem_r;
  logic                  first_step_r;
  logic [SLOT_W-1:0]     tgt_r;
  logic [SLOT_W-1:0]     link_q_r;
  logic [SLOT_W-1:0]     cur_r;
  logic [VALUE_BITS-1:0] val_q_r;
  logic [SLOT_W-1:0]     free_q_r;
  logic                  free_hit_r;
  logic [SLOT_W-1:0]     free_idx_r;

  // Result register.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_BITS-1:0] out_rd_r;
  logic [LEN_W-1:0]      out_count_r;

  logic                  is_append;
  logic                  full;
  logic [STATUS_W-1:0]   err;
  logic [SLOT_W-1:0]     walk_addr;
  logic [SLOT_W-1:0]     walk_cnt;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     free_rd_idx;
  logic [SLOT_W-1:0]     free_wr_idx;
  logic                  link_rd_en;
  logic [SLOT_W-1:0]     link_rd_addr;
  logic                  link_wr_en;
  logic [SLOT_W-1:0]     link_wr_addr;
  logic [SLOT_W-1:0]     link_wr_data;
  logic                  val_wr_en;
  logic [SLOT_W-1:0]     val_wr_addr;
  logic                  free_wr_en;
  logic [SLOT_W-1:0]     free_wr_data;

  assign is_append = (req_r == REQ_APPEND);
  assign full      = (len_r == LEN_W'(CAPACITY));

  always_comb begin
    unique case (req_r)
      REQ_APPEND:    err = full ? ST_FULL : ST_DONE;
      REQ_INSERT: begin
        priority if (pos_r > len_r) err = ST_RANGE;
        else if (full) err = ST_FULL;
        else err = ST_DONE;
      end
      REQ_REMOVE,
      REQ_READ,
      REQ_OVERWRITE: err = (pos_r >= len_r) ? ST_RANGE : ST_DONE;
      default:       err = ST_RANGE;
    endcase
  end

  // The first walk step reads the head's link; later steps follow the link
  // that came back in the previous cycle.
  assign walk_addr   = first_step_r ? first_r : link_q_r;
  assign walk_cnt    = ((req_r == REQ_READ) || (req_r == REQ_OVERWRITE)) ?
                       pos_r[SLOT_W-1:0] : pos_r[SLOT_W-1:0] - 1'b1;
  assign free_slot   = free_hit_r ? free_q_r : free_idx_r;
  assign free_rd_idx = SLOT_W'(LEN_W'(CAPACITY - 1) - len_r);
  assign free_wr_idx = SLOT_W'(LEN_W'(CAPACITY) - len_r);

  always_comb begin
    sts.err       = err;
    sts.is_ins    = is_append || (req_r == REQ_INSERT);
    sts.is_rm     = (req_r == REQ_REMOVE);
    sts.is_rd     = (req_r == REQ_READ);
    sts.is_ovw    = (req_r == REQ_OVERWRITE);
    sts.at_head   = is_append ? (len_r == '0) : (pos_r == '0);
    sts.at_tail   = is_append || (pos_r == len_r);
    sts.walk_done = (rem_r == '0);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // Memory port selection.
  always_comb begin
    link_rd_en   = 1'b0;
    link_rd_addr = walk_addr;
    link_wr_en   = 1'b0;
    link_wr_addr = tgt_r;
    link_wr_data = free_slot;
    val_wr_en    = 1'b0;
    val_wr_addr  = free_slot;
    free_wr_en   = 1'b0;
    free_wr_data = cur_r;
    unique case (cmd_op)
      DP_WALK: begin
        link_rd_en = 1'b1;
      end
      DP_LINK_RD_TGT: begin
        link_rd_en   = 1'b1;
        link_rd_addr = tgt_r;
      end
      DP_RM_HEAD_RD: begin
        link_rd_en   = 1'b1;
        link_rd_addr = first_r;
      end
      DP_RM_RD2: begin
        link_rd_en   = 1'b1;
        link_rd_addr = link_q_r;
      end
      DP_VAL_WR: begin
        val_wr_en   = 1'b1;
        val_wr_addr = tgt_r;
      end
      DP_INS_HEAD: begin
        val_wr_en    = 1'b1;
        link_wr_en   = 1'b1;
        link_wr_addr = free_slot;
        link_wr_data = first_r;
      end
      DP_INS_TAIL: begin
        val_wr_en    = 1'b1;
        link_wr_en   = 1'b1;
        link_wr_addr = last_r;
      end
      DP_INS_LINK: begin
        val_wr_en    = 1'b1;
        link_wr_en   = 1'b1;
        link_wr_addr = free_slot;
        link_wr_data = link_q_r;
      end
      DP_INS_FIX: begin
        link_wr_en = 1'b1;
      end
      DP_RM_HEAD_UPD: begin
        free_wr_en   = 1'b1;
        free_wr_data = first_r;
      end
      DP_RM_UPD: begin
        link_wr_en   = 1'b1;
        link_wr_data = link_q_r;
        free_wr_en   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_rd_en) link_q_r <= link_mem[link_rd_addr];
    if (link_wr_en) link_mem[link_wr_addr] <= link_wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd_op == DP_VAL_RD) val_q_r <= val_mem[tgt_r];
    if (val_wr_en) val_mem[val_wr_addr] <= wv_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_op == DP_CHECK) begin
      free_q_r   <= free_mem[free_rd_idx];
      free_idx_r <= free_rd_idx;
    end
    if (free_wr_en) free_mem[free_wr_idx] <= free_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_vld_r <= '0;
      free_hit_r <= 1'b0;
    end else begin
      if (cmd_op == DP_CHECK) free_hit_r <= free_vld_r[free_rd_idx];
      if (free_wr_en) free_vld_r[free_wr_idx] <= 1'b1;
    end
  end

  // Request capture, walk cursor and saved slots.
  always_ff @(posedge clk) begin
    unique case (cmd_op)
      DP_LOAD: begin
        req_r <= in_req_type;
        pos_r <= in_position;
        wv_r  <= in_write_value;
      end
      DP_CHECK: begin
        status_r     <= err;
        rem_r        <= walk_cnt;
        first_step_r <= 1'b1;
      end
      DP_WALK: begin
        if (rem_r == '0) begin
          tgt_r <= walk_addr;
        end else begin
          rem_r        <= rem_r - 1'b1;
          first_step_r <= 1'b0;
        end
      end
      DP_RM_RD2: cur_r <= link_q_r;
      default: begin
      end
    endcase
  end

  // Chain ends and entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else begin
      unique case (cmd_op)
        DP_INS_HEAD: begin
          first_r <= free_slot;
          if (len_r == '0) last_r <= free_slot;
          len_r <= len_r + 1'b1;
        end
        DP_INS_TAIL: begin
          last_r <= free_slot;
          len_r  <= len_r + 1'b1;
        end
        DP_INS_FIX: begin
          len_r <= len_r + 1'b1;
        end
        DP_RM_HEAD_UPD: begin
          // Removing the only entry leaves both ends at slot zero.
          if (len_r == LEN_W'(1)) begin
            first_r <= '0;
            last_r  <= '0;
          end else begin
            first_r <= link_q_r;
          end
          len_r <= len_r - 1'b1;
        end
        DP_RM_UPD: begin
          if (pos_r == len_r - 1'b1) last_r <= tgt_r;
          len_r <= len_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_op == DP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_op == DP_FINISH) begin
      out_status_r <= status_r;
      out_rd_r     <= ((req_r == REQ_READ) && (status_r == ST_DONE)) ? val_q_r : '0;
      out_count_r  <= len_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rd_r;
  assign out_entry_count = out_count_r;

  `ILS_ASSERT(a_len_bound, len_r <= LEN_W'(CAPACITY), "entry count above capacity")
  `ILS_ASSERT(a_len_step, (len_r == $past(len_r)) || (len_r == $past(len_r) + 1'b1) || (len_r == $past(len_r) - 1'b1), "entry count moved by more than one")
  `ILS_ASSERT_IMP(a_ins_room, (cmd_op == DP_INS_HEAD) || (cmd_op == DP_INS_TAIL) || (cmd_op == DP_INS_FIX), len_r != LEN_W'(CAPACITY), "insert on a full store")
  `ILS_ASSERT_IMP(a_rm_nonempty, (cmd_op == DP_RM_HEAD_UPD) || (cmd_op == DP_RM_UPD), len_r != '0, "remove on an empty store")

endmodule

`default_nettype wire

FILE: sim/indexed_list_store_checker.sv
// ---------------------------------------------------------------------------
// indexed_list_store_checker
// Watches both channels of the list store, keeps its own ordered copy of the
// stored values, and compares each result with the prediction for the
// oldest request still waiting for one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_store_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [ils_pkg::REQ_W-1:0]             in_req_type,
  input  logic [ils_pkg::POS_W-1:0]             in_position,
  input  logic signed [ils_pkg::VALUE_BITS-1:0] in_write_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [ils_pkg::STATUS_W-1:0]          out_status,
  input  logic signed [ils_pkg::VALUE_BITS-1:0] out_read_value,
  input  logic [ils_pkg::LEN_W-1:0]             out_entry_count,
  output int                                    fail_count,
  output int                                    pending
);
  import ils_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [LEN_W-1:0]            entry_count;
  } list_result_t;

  // Entries in list order; index i is list position i.
  logic signed [VALUE_BITS-1:0] stored_values[$];
  list_result_t                 awaited_results[$];
  list_result_t                 oldest;
  list_result_t                 observed;

  function automatic list_result_t apply_request(logic [REQ_W-1:0] req,
                                                 logic [POS_W-1:0] pos,
                                                 logic signed [VALUE_BITS-1:0] value);
    list_result_t res;
    int           held;
    int           idx;
    res    = '0;
    held   = stored_values.size();
    idx    = int'(pos);
    res.status = ST_DONE;
    case (req)
      REQ_APPEND: begin
        if (held >= CAPACITY) res.status = ST_FULL;
        else stored_values.push_back(value);
      end
      REQ_INSERT: begin
        // The range check wins over the full check.
        if (idx > held) res.status = ST_RANGE;
        else if (held >= CAPACITY) res.status = ST_FULL;
        else stored_values.insert(idx, value);
      end
      REQ_REMOVE: begin
        if (idx >= held) res.status = ST_RANGE;
        else stored_values.delete(idx);
      end
      REQ_READ: begin
        if (idx >= held) res.status = ST_RANGE;
        else res.read_value = stored_values[idx];
      end
      REQ_OVERWRITE: begin
        if (idx >= held) res.status = ST_RANGE;
        else stored_values[idx] = value;
      end
      default: res.status = ST_RANGE;
    endcase
    res.entry_count = LEN_W'(stored_values.size());
    return res;
  endfunction

  task automatic report_field(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored_values.delete();
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(apply_request(in_req_type, in_position, in_write_value));
      if (out_valid && out_ready) begin
        observed.status      = out_status;
        observed.read_value  = out_read_value;
        observed.entry_count = out_entry_count;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual status %0d value %0d count %0d",
                   $time, observed.status, observed.read_value, observed.entry_count);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (observed.status !== oldest.status)
            report_field("status", oldest.status, observed.status);
          if (observed.read_value !== oldest.read_value)
            report_field("read_value", oldest.read_value, observed.read_value);
          if (observed.entry_count !== oldest.entry_count)
            report_field("entry_count", oldest.entry_count, observed.entry_count);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

FILE: sim/indexed_list_store_tb.sv
// ---------------------------------------------------------------------------
// indexed_list_store_tb
// Drives the list store with a directed opening and then random traffic that
// fills the store to capacity, drains it and mixes requests, with random
// gaps on both channels. The checker module judges every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int TOTAL_ITEMS = 1050;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 300;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED_TRAFFIC} traffic_mode_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [REQ_W-1:0]             in_req_type = '0;
  logic [POS_W-1:0]             in_position = '0;
  logic signed [VALUE_BITS-1:0] in_write_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [STATUS_W-1:0]          out_status;
  logic signed [VALUE_BITS-1:0] out_read_value;
  logic [LEN_W-1:0]             out_entry_count;

  int fail_count;
  int pending;
  int sent_count  = 0;
  int taken_count = 0;
  int list_len    = 0;
  int idle_cycles = 0;

  indexed_list_store uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

  indexed_list_store_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every fourth stretch of 64 items runs with no idling at all.
  function automatic int draw_gap(int idx);
    if ((idx / 64) % 4 == 3) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Valid position below span, leaning toward both ends of the list.
  function automatic int pick_position(int span);
    if (span <= 1) return 0;
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return span - 1;
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  task automatic send_item(logic [REQ_W-1:0] req, int pos, logic [VALUE_BITS-1:0] value);
    int gap;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_position    <= pos[POS_W-1:0];
    in_write_value <= value;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    // Track the length only to steer positions toward the valid range.
    case (req)
      REQ_APPEND: if (list_len < CAPACITY) list_len++;
      REQ_INSERT: if (pos[POS_W-1:0] <= list_len && list_len < CAPACITY) list_len++;
      REQ_REMOVE: if (pos[POS_W-1:0] < list_len) list_len--;
      default: ;
    endcase
  endtask

  initial begin
    traffic_mode_t    mode;
    int               mixed_left;
    int               roll;
    logic [REQ_W-1:0] req;
    int               pos;
    mode       = FILL_UP;
    mixed_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Requests against an empty store, then unknown request codes.
    send_item(REQ_READ, 0, 32'h0000_0001);
    send_item(REQ_REMOVE, 0, 32'h0);
    send_item(REQ_OVERWRITE, 0, 32'h5555_5555);
    send_item(REQ_INSERT, 1, 32'h1111_1111);
    send_item(3'd5, 511, 32'hFFFF_FFFF);
    send_item(3'd6, 0, 32'h0);
    send_item(3'd7, 256, 32'h8000_0000);
    // Build a short list using both ends and the middle.
    send_item(REQ_INSERT, 0, 32'h8000_0000);
    send_item(REQ_APPEND, 0, 32'h7FFF_FFFF);
    send_item(REQ_APPEND, 511, 32'h0);
    send_item(REQ_INSERT, 3, 32'hFFFF_FFFF);
    send_item(REQ_INSERT, 2, 32'h1234_5678);
    for (int i = 0; i < 5; i++) send_item(REQ_READ, i, 32'hFFFF_FFFF);
    send_item(REQ_OVERWRITE, 4, 32'hA5A5_A5A5);
    send_item(REQ_READ, 5, 32'h0);
    send_item(REQ_REMOVE, 4, 32'h0);
    send_item(REQ_REMOVE, 0, 32'h0);
    send_item(REQ_REMOVE, 1, 32'h0);
    send_item(REQ_READ, 511, 32'h0);
    send_item(REQ_OVERWRITE, 256, 32'h0F0F_0F0F);
    send_item(REQ_INSERT, 511, 32'hDEAD_BEEF);
    send_item(REQ_READ, 1, 32'h0);

    while (sent_count < TOTAL_ITEMS) begin
      if (mode == FILL_UP && list_len == CAPACITY) begin
        // Probe the full store from every side before draining it.
        send_item(REQ_APPEND, $urandom_range(0, 511), $urandom);
        send_item(REQ_INSERT, $urandom_range(0, CAPACITY), $urandom);
        send_item(REQ_INSERT, CAPACITY, $urandom);
        send_item(REQ_INSERT, $urandom_range(CAPACITY + 1, 511), $urandom);
        send_item(REQ_READ, CAPACITY - 1, $urandom);
        send_item(REQ_OVERWRITE, CAPACITY - 1, $urandom);
        send_item(REQ_READ, CAPACITY, $urandom);
        mode = DRAIN_DOWN;
      end else if (mode == DRAIN_DOWN && list_len <= 4) begin
        mode       = MIXED_TRAFFIC;
        mixed_left = 60;
      end else if (mode == MIXED_TRAFFIC && mixed_left == 0) begin
        mode = FILL_UP;
      end

      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        req = REQ_W'($urandom_range(0, 7));
        pos = $urandom_range(0, 511);
      end else begin
        roll = $urandom_range(0, 99);
        case (mode)
          FILL_UP:    req = (roll < 45) ? REQ_APPEND : (roll < 78) ? REQ_INSERT :
                            (roll < 90) ? REQ_READ : REQ_OVERWRITE;
          DRAIN_DOWN: req = (roll < 70) ? REQ_REMOVE : (roll < 84) ? REQ_READ :
                            (roll < 92) ? REQ_OVERWRITE : (roll < 96) ? REQ_APPEND :
                            REQ_INSERT;
          default:    req = (roll < 20) ? REQ_APPEND : (roll < 40) ? REQ_INSERT :
                            (roll < 60) ? REQ_REMOVE : (roll < 80) ? REQ_READ :
                            REQ_OVERWRITE;
        endcase
        if (req == REQ_INSERT) pos = pick_position(list_len + 1);
        else if (list_len == 0) pos = $urandom_range(0, 511);
        else pos = pick_position(list_len);
      end
      send_item(req, pos, $urandom);
      if (mode == MIXED_TRAFFIC) mixed_left--;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_list_store verification clean");
    end else begin
      $display("indexed_list_store verification failed");
    end
    $finish;
  end

  // Result side: stall a random number of cycles before taking each item.
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap(taken_count);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("indexed_list_store verification failed");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ils_pkg.sv
hdl/ils_ctrl.sv
hdl/ils_dpath.sv
hdl/indexed_list_store.sv
sim/indexed_list_store_checker.sv
sim/indexed_list_store_tb.sv
